>>> rtl/horizontal_area_downscaler_assert.svh
// assertion macros shared by the checker
`ifndef HORIZONTAL_AREA_DOWNSCALER_ASSERT_SVH
`define HORIZONTAL_AREA_DOWNSCALER_ASSERT_SVH

// a condition that must imply another at the same edge
`define HAD_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// a condition that must imply another at the next edge
`define HAD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

>>> rtl/had_pkg.sv
package had_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int VALUE_W     = 20;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCALE_FROM     = 2'd0,
		REG_SCALE_TO       = 2'd1,
		REG_INITIAL_WEIGHT = 2'd2,
		REG_OUT_WIDTH      = 2'd3
	} cfg_reg_t;

endpackage

>>> rtl/horizontal_area_downscaler.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------------
// s_*       | in        | s_tvalid/s_tready  | tdata: sample [7:0]; tlast: row_end
// m_*       | out       | m_tvalid/m_tready  | tdata: scaled_value [19:0], zero [23:20];
//           |           |                    | tlast: last_output
// cfg_*     | in        | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value
//
// one sample per clock sustained: a sample is registered on entry (s1), the phase
// arithmetic and both multiplies sit between that register and the result register (s2)
// and the row state updates in the same cycle, so each transaction reaches its result through
// s1 and then s2. the s1 and s2 stages advance together whenever the result register is
// empty or being drained; only a stalled result holds the input side.
// arst_n clears all control state and loads the register reset values.
module horizontal_area_downscaler #(
	parameter int RATIO_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [had_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [RATIO_BITS:0]                 cfg_data,
	// input samples
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [had_pkg::SAMPLE_W-1:0]        s_tdata,  // [7:0] sample
	input  logic                                s_tlast,  // row_end
	// scaled results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [had_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [19:0] scaled_value, [23:20] zero
	output logic                                m_tlast   // last_output
);
	import had_pkg::*;

	// phase weight carries two bits over the ratio width
	localparam int PW = RATIO_BITS + 2;
	localparam int RB = RATIO_BITS;
	localparam int VW = VALUE_W;

	// configuration registers
	logic [RB-1:0] scale_from_q;
	logic [RB-1:0] scale_to_q;
	logic [RB:0]   init_weight_q;
	logic [RB-1:0] out_width_q;

	// row state
	logic [PW-1:0] phase_q;
	logic [VW-1:0] whole_q;
	logic [VW-1:0] carry_q;
	logic [RB-1:0] done_q;
	logic          started_q;

	// pipeline registers
	logic                 valid_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic                 last_s1;
	logic                 valid_s2;
	logic [VW-1:0]        value_s2;
	logic                 last_s2;

	logic advance;
	logic fire;

	// datapath signals
	logic [PW-1:0]          init_pw;
	logic [PW-1:0]          w_cur;
	logic                   w_neg;
	logic                   w_zero;
	logic [PW-1:0]          step_pw;
	logic [PW-1:0]          sto_pw;
	logic [VW-1:0]          w20;
	logic [VW-1:0]          neg_w20;
	logic [VW-1:0]          sum_ws;
	logic [VW+SAMPLE_W-1:0] prod_b_full;
	logic [VW+RB-1:0]       prod_a_full;
	logic [VW-1:0]          prod_a;
	logic [VW-1:0]          prod_b;
	logic [VW-1:0]          value_c;
	logic [RB-1:0]          done_inc;
	logic                   active;

	// next row state
	logic [PW-1:0] phase_n;
	logic [VW-1:0] whole_n;
	logic [VW-1:0] carry_n;
	logic [RB-1:0] done_n;
	logic          started_n;
	logic          emit;

	// stages move together when the result slot is free or being drained
	assign advance   = !valid_s2 || m_tready;
	assign fire      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W-VW){1'b0}}, value_s2};
	assign m_tlast  = last_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_from_q  <= RB'(2);
			scale_to_q    <= RB'(1);
			init_weight_q <= '0;
			out_width_q   <= RB'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCALE_FROM:     scale_from_q  <= cfg_data[RB-1:0];
				REG_SCALE_TO:       scale_to_q    <= cfg_data[RB-1:0];
				REG_INITIAL_WEIGHT: init_weight_q <= cfg_data;
				REG_OUT_WIDTH:      out_width_q   <= cfg_data[RB-1:0];
				default: ;
			endcase
		end
	end

	// phase weight: first sample of a row takes it from the register
	assign init_pw = {init_weight_q[RB], init_weight_q};
	assign w_cur   = started_q ? phase_q : init_pw;
	assign w_neg   = w_cur[PW-1];
	assign w_zero  = (w_cur == '0);
	assign sto_pw  = {2'b00, scale_to_q};
	assign step_pw = {2'b00, scale_from_q} - sto_pw;

	// only the low 20 bits of any product are kept, so work modulo 2^20
	assign w20         = {{(VW-PW){w_cur[PW-1]}}, w_cur};
	assign neg_w20     = (~w20) + VW'(1);
	assign sum_ws      = whole_q + VW'(sample_s1);
	// (whole + s) * scale_to
	assign prod_a_full = sum_ws * scale_to_q;
	// s * (-w), boundary carry
	assign prod_b_full = sample_s1 * neg_w20;
	assign prod_a      = prod_a_full[VW-1:0];
	assign prod_b      = prod_b_full[VW-1:0];
	// boundary share s * (w + scale_to) folds into prod_a minus prod_b
	assign value_c     = carry_q + prod_a - (w_neg ? prod_b : '0);
	assign done_inc    = done_q + RB'(1);
	assign active      = (done_q < out_width_q);

	always_comb begin
		phase_n   = phase_q;
		whole_n   = whole_q;
		carry_n   = carry_q;
		done_n    = done_q;
		started_n = 1'b1;
		emit      = 1'b0;
		if (!started_q)
			phase_n = init_pw;
		if (!started_q && w_neg) begin
			// preload of the first sample into the carry
			carry_n = prod_b;
			phase_n = w_cur + step_pw;
		end else if (active) begin
			if (!w_neg && !w_zero) begin
				// whole sample
				whole_n = sum_ws;
				phase_n = w_cur - sto_pw;
			end else begin
				// boundary sample closes one result
				carry_n = w_neg ? prod_b : '0;
				phase_n = w_neg ? (w_cur + step_pw) : step_pw;
				whole_n = '0;
				done_n  = done_inc;
				emit    = 1'b1;
			end
		end
		if (last_s1) begin
			// row end returns to start-of-row values
			started_n = 1'b0;
			whole_n   = '0;
			carry_n   = '0;
			done_n    = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			whole_q   <= '0;
			carry_q   <= '0;
			done_q    <= '0;
			started_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_n;
			whole_q   <= whole_n;
			carry_q   <= carry_n;
			done_q    <= done_n;
			started_q <= started_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			value_s2 <= value_c;
			last_s2  <= (done_inc == out_width_q);
		end
	end

endmodule

>>> rtl/had_checker.sv
`include "horizontal_area_downscaler_assert.svh"

module had_checker #(
	parameter int RATIO_BITS = 12
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [had_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input logic [RATIO_BITS:0]                 cfg_data,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [had_pkg::SAMPLE_W-1:0]        s_tdata,  // [7:0] sample
	input logic                                s_tlast,  // row_end
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [had_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [19:0] scaled_value, [23:20] zero
	input logic                                m_tlast   // last_output
);
	import had_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{cfg_index, cfg_data, s_tdata, s_tlast, m_tlast, cfg_valid};

	// stalled result stays offered
	`HAD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// stalled result keeps its value
	`HAD_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// padding above the value is zero
	`HAD_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid,
		m_tdata[OUT_TDATA_W-1:VALUE_W] == '0)
	// an empty result slot never blocks input
	`HAD_ASSERT_IMPLY(a_ready_free, clk, arst_n, !m_tvalid, s_tready && cfg_ready)
	// a fresh result follows an input transaction through the input and result registers
	`HAD_ASSERT_IMPLY(a_out_cause, clk, arst_n, $rose(m_tvalid),
		$past(s_tvalid && s_tready, 2))

endmodule

bind horizontal_area_downscaler had_checker #(.RATIO_BITS(RATIO_BITS)) u_had_checker (.*);
